// ----- rtl/murmur64a_hash_top_assert.svh -----
// Assertion macros for the MurmurHash64A block.
`ifndef MURMUR64A_HASH_TOP_ASSERT_SVH
`define MURMUR64A_HASH_TOP_ASSERT_SVH

`ifndef SYNTHESIS

`define MMH_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`define MMH_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define MMH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MMH_ASSERT_NEVER(lbl, clk, rst, cond, msg)

`define MMH_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)

`define MMH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ----- rtl/mmh_pkg.sv -----
// Shared types and constants of the MurmurHash64A block.
package mmh_pkg;

   localparam int unsigned WORD_W      = 64;
   localparam int unsigned COUNT_W     = 4;
   localparam int unsigned KLEN_W      = 31;
   localparam int unsigned HALF_W      = WORD_W / 2;
   localparam int unsigned REQ_TDATA_W = ((WORD_W + COUNT_W + KLEN_W + 7) / 8) * 8;

   localparam int unsigned COUNT_LSB = WORD_W;
   localparam int unsigned KLEN_LSB  = WORD_W + COUNT_W;

   localparam logic [WORD_W-1:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
   localparam logic [WORD_W-1:0] SEED      = 64'hdeadbeefdeadbeef;
   localparam int unsigned       MIX_SHIFT = 47;
   localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_TAIL = 2'd1,
      KIND_FULL = 2'd2
   } kind_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      kind_type          kind;
      logic              first;
      logic              last;
      logic [KLEN_W-1:0] klen;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic pop;
      logic emit;
   } back_status_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_SEED = 7'b0000010,
      ST_K1   = 7'b0000100,
      ST_K2   = 7'b0001000,
      ST_TAIL = 7'b0010000,
      ST_HMUL = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

   function automatic logic [WORD_W-1:0] xorshift(input logic [WORD_W-1:0] v);
      xorshift = v ^ (v >> MIX_SHIFT);
   endfunction

endpackage

// ----- rtl/mmh_front.sv -----
// Request intake: splits the request bus and classifies each key word.
module mmh_front (
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mmh_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                               req_tuser,
   input  logic                               req_tlast,
   input  mmh_pkg::queue_status_type          q_status,
   output logic                               push,
   output mmh_pkg::item_type                  push_item
);
   import mmh_pkg::*;

   logic [WORD_W-1:0]  word;
   logic [COUNT_W-1:0] count;
   logic [WORD_W-1:0]  mask;

   assign word       = req_tdata[WORD_W-1:0];
   assign count      = req_tdata[COUNT_LSB +: COUNT_W];
   assign mask       = ~({WORD_W{1'b1}} << {count[2:0], 3'b000});
   assign req_tready = ~q_status.full;
   assign push       = req_tvalid & ~q_status.full;

   always_comb begin
      push_item.first = req_tuser;
      push_item.last  = req_tlast;
      push_item.klen  = req_tdata[KLEN_LSB +: KLEN_W];
      push_item.word  = word;
      if (count >= FULL_COUNT) begin
         push_item.kind = KIND_FULL;
      end else if (count == '0) begin
         push_item.kind = KIND_NONE;
      end else begin
         push_item.kind = KIND_TAIL;
         push_item.word = word & mask;
      end
   end

endmodule

// ----- rtl/mmh_queue.sv -----
// Short queue of classified words between the intake and the hash engine.
module mmh_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  mmh_pkg::item_type         push_item,
   input  logic                      pop,
   output mmh_pkg::item_type         head,
   output mmh_pkg::queue_status_type status
);
   import mmh_pkg::*;

   item_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign head         = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ----- rtl/mmh_mul.sv -----
// Two-stage multiplier by the mixing constant, modulo 2^64, from 32-bit partial products.
module mmh_mul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [mmh_pkg::WORD_W-1:0] operand,
   output logic                       done,
   output logic [mmh_pkg::WORD_W-1:0] product
);
   import mmh_pkg::*;

   logic [HALF_W-1:0] a_lo, a_hi, m_lo, m_hi;
   logic [WORD_W-1:0] pp_lo_in, pp_lo_ff;
   logic [HALF_W-1:0] pp_x1_in, pp_x1_ff;
   logic [HALF_W-1:0] pp_x2_in, pp_x2_ff;
   logic [HALF_W-1:0] cross_sum;
   logic [WORD_W-1:0] prod_in, prod_ff;
   logic              va_ff, vb_ff;

   assign a_lo = operand[HALF_W-1:0];
   assign a_hi = operand[WORD_W-1:HALF_W];
   assign m_lo = MIX_MUL[HALF_W-1:0];
   assign m_hi = MIX_MUL[WORD_W-1:HALF_W];

   assign pp_lo_in  = WORD_W'(a_lo) * WORD_W'(m_lo);
   assign pp_x1_in  = a_lo * m_hi;
   assign pp_x2_in  = a_hi * m_lo;
   assign cross_sum = pp_x1_ff + pp_x2_ff;
   assign prod_in   = pp_lo_ff + {cross_sum, {HALF_W{1'b0}}};

   assign done    = vb_ff;
   assign product = prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= start;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      pp_lo_ff <= pp_lo_in;
      pp_x1_ff <= pp_x1_in;
      pp_x2_ff <= pp_x2_in;
      prod_ff  <= prod_in;
   end

endmodule

// ----- rtl/mmh_back.sv -----
// Hash engine: sequences seeding, word mixing and finalization, and holds the result register.
module mmh_back (
   input  logic                       clock,
   input  logic                       reset,
   input  mmh_pkg::queue_status_type  q_status,
   input  mmh_pkg::item_type          head,
   output mmh_pkg::back_status_type   status,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [mmh_pkg::WORD_W-1:0] rsp_tdata
);
   import mmh_pkg::*;

   state_type         state_ff, state_in;
   item_type          cur_ff, cur_in;
   logic [WORD_W-1:0] h_ff, h_in;
   logic [WORD_W-1:0] k_ff, k_in;
   logic              pend_ff, pend_in;
   logic              out_valid_ff, out_valid_in;
   logic [WORD_W-1:0] out_data_ff, out_data_in;
   logic              out_pend_ff, out_pend_in;

   logic              mul_start, mul_done, mul_state;
   logic [WORD_W-1:0] mul_op, mul_prod;

   function automatic state_type after_seed(input kind_type kind, input logic last);
      case (kind)
         KIND_FULL: after_seed = ST_K1;
         KIND_TAIL: after_seed = ST_TAIL;
         default:   after_seed = last ? ST_FIN : ST_IDLE;
      endcase
   endfunction

   mmh_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .operand (mul_op),
      .done    (mul_done),
      .product (mul_prod)
   );

   assign mul_state = (state_ff == ST_SEED) || (state_ff == ST_K1) || (state_ff == ST_K2) ||
                      (state_ff == ST_HMUL) || (state_ff == ST_FIN);
   assign mul_start = mul_state & ~pend_ff;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_comb begin
      case (state_ff)
         ST_SEED: mul_op = {{(WORD_W - KLEN_W){1'b0}}, cur_ff.klen};
         ST_K1:   mul_op = cur_ff.word;
         ST_K2:   mul_op = k_ff;
         ST_FIN:  mul_op = xorshift(h_ff);
         default: mul_op = h_ff;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      h_in         = h_ff;
      k_in         = k_ff;
      pend_in      = pend_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_pend_in  = out_pend_ff;
      status.pop   = 1'b0;
      status.emit  = 1'b0;

      if (mul_start) begin
         pend_in = 1'b1;
      end else if (mul_done) begin
         pend_in = 1'b0;
      end

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      if (out_pend_ff && (!out_valid_ff || rsp_tready)) begin
         out_valid_in = 1'b1;
         out_data_in  = k_ff;
         out_pend_in  = 1'b0;
         status.emit  = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty && !out_pend_ff) begin
               status.pop = 1'b1;
               cur_in     = head;
               state_in   = head.first ? ST_SEED : after_seed(head.kind, head.last);
            end
         end
         ST_SEED: begin
            if (mul_done) begin
               h_in     = SEED ^ mul_prod;
               state_in = after_seed(cur_ff.kind, cur_ff.last);
            end
         end
         ST_K1: begin
            if (mul_done) begin
               k_in     = xorshift(mul_prod);
               state_in = ST_K2;
            end
         end
         ST_K2: begin
            if (mul_done) begin
               h_in     = h_ff ^ mul_prod;
               state_in = ST_HMUL;
            end
         end
         ST_TAIL: begin
            h_in     = h_ff ^ cur_ff.word;
            state_in = ST_HMUL;
         end
         ST_HMUL: begin
            if (mul_done) begin
               h_in     = mul_prod;
               state_in = cur_ff.last ? ST_FIN : ST_IDLE;
            end
         end
         ST_FIN: begin
            if (mul_done) begin
               k_in        = xorshift(mul_prod);
               out_pend_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         h_ff         <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         out_pend_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         h_ff         <= h_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
         out_pend_ff  <= out_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      k_ff        <= k_in;
      out_data_ff <= out_data_in;
   end

endmodule

// ----- rtl/murmur64a_hash_top.sv -----
// Top level of the MurmurHash64A block with seed 0xdeadbeefdeadbeef.
// Keys arrive as little-endian 64-bit words, one request per word; req_tuser marks the first
// word, which carries the key length, and req_tlast marks the final word, which produces one
// 64-bit hash on the response bus. Requests enter a two-entry queue and are worked off one at a
// time by an engine built around a shared two-stage multiplier by the mixing constant. A word
// leaves the queue and then takes its multiplies in turn: three for a full word, one after a
// step of folding for a partial word, none for a word of zero bytes, one more on a first word,
// and on a last word one more plus a step to hand the hash to the response register.
// The response register lets the engine move on to the next word while a finished hash waits
// to be taken.
`include "murmur64a_hash_top_assert.svh"

module murmur64a_hash_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // key_word [63:0], byte_count [67:64], key_length [98:68], zero fill [103:99]
   input  logic [mmh_pkg::REQ_TDATA_W-1:0] req_tdata,
   // is_first [0]
   input  logic                            req_tuser,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // hash_value [63:0]
   output logic [mmh_pkg::WORD_W-1:0]      rsp_tdata
);
   import mmh_pkg::*;

   queue_status_type q_status;
   back_status_type  b_status;
   item_type         push_item;
   item_type         head;
   logic             push;

   mmh_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_status   (q_status),
      .push       (push),
      .push_item  (push_item)
   );

   mmh_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (b_status.pop),
      .head      (head),
      .status    (q_status)
   );

   mmh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .head       (head),
      .status     (b_status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   `MMH_ASSERT_NEVER(a_pop_when_empty, clock, reset, b_status.pop && q_status.empty, "Engine took a request from an empty queue.")
   `MMH_ASSERT_NEXT(a_push_lands, clock, reset, push && q_status.empty, !q_status.empty, "Accepted request did not reach the queue.")
   `MMH_ASSERT_IMPLY(a_emit_source, clock, reset, $rose(rsp_tvalid), $past(b_status.emit), "Response appeared without a finished hash.")

endmodule

// ----- test/murmur64a_hash_top_tb.sv -----
// Testbench for murmur64a_hash_top: a directed table and random keys, checked against a hash predictor.
module murmur64a_hash_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mmh_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1830;
   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned SETTLE_CYCLES = 64;
   localparam int unsigned ROW_COUNT    = 21;

   typedef struct packed {
      logic [WORD_W-1:0]  word;
      logic [COUNT_W-1:0] count;
      logic               is_first;
      logic               is_last;
      logic [KLEN_W-1:0]  klen;
      logic               typed;
      logic [WORD_W-1:0]  hash;
   } request_row;

   // The first row follows reset: no seed and no bytes leave a zero hash, and zero finalizes to zero.
   localparam request_row DIRECTED_ROWS [0:ROW_COUNT-1] = '{
      '{64'hffff_ffff_ffff_ffff, 4'd0,  1'b0, 1'b1, 31'd0,          1'b1, 64'd0},
      '{64'h0000_0000_0000_0000, 4'd0,  1'b1, 1'b1, 31'd0,          1'b0, 64'd0},
      '{64'h0123_4567_89ab_cdef, 4'd0,  1'b1, 1'b1, 31'h7fff_ffff,  1'b0, 64'd0},
      '{64'hffff_ffff_ffff_ffff, 4'd8,  1'b1, 1'b1, 31'd8,          1'b0, 64'd0},
      '{64'h0000_0000_0000_0000, 4'd8,  1'b1, 1'b1, 31'd8,          1'b0, 64'd0},
      '{64'h0123_4567_89ab_cdef, 4'd15, 1'b1, 1'b1, 31'd8,          1'b0, 64'd0},
      '{64'hfedc_ba98_7654_3210, 4'd9,  1'b1, 1'b1, 31'd8,          1'b0, 64'd0},
      '{64'h5555_5555_5555_5555, 4'd8,  1'b1, 1'b0, 31'd20,         1'b0, 64'd0},
      '{64'haaaa_aaaa_aaaa_aaaa, 4'd8,  1'b0, 1'b0, 31'd20,         1'b0, 64'd0},
      '{64'h8000_0000_0000_0001, 4'd4,  1'b0, 1'b1, 31'd20,         1'b0, 64'd0},
      '{64'hffff_ffff_ffff_ffff, 4'd1,  1'b1, 1'b1, 31'd1,          1'b0, 64'd0},
      '{64'hffff_ffff_ffff_ffff, 4'd7,  1'b1, 1'b1, 31'd7,          1'b0, 64'd0},
      '{64'h0f0f_0f0f_0f0f_0f0f, 4'd3,  1'b1, 1'b0, 31'd11,         1'b0, 64'd0},
      '{64'hf0f0_f0f0_f0f0_f0f0, 4'd8,  1'b0, 1'b1, 31'd11,         1'b0, 64'd0},
      '{64'h1234_5678_9abc_def0, 4'd8,  1'b0, 1'b1, 31'd0,          1'b0, 64'd0},
      '{64'hdead_beef_0bad_f00d, 4'd0,  1'b0, 1'b0, 31'd0,          1'b0, 64'd0},
      '{64'hcafe_babe_1357_9bdf, 4'd5,  1'b0, 1'b1, 31'd0,          1'b0, 64'd0},
      '{64'h7777_7777_7777_7777, 4'd8,  1'b1, 1'b1, 31'h7fff_ffff,  1'b0, 64'd0},
      '{64'h9999_9999_9999_9999, 4'd8,  1'b1, 1'b0, 31'd16,         1'b0, 64'd0},
      '{64'h3c3c_3c3c_3c3c_3c3c, 4'd2,  1'b1, 1'b1, 31'd2,          1'b0, 64'd0},
      '{64'h0000_0000_0000_0001, 4'd6,  1'b1, 1'b1, 31'h4000_0000,  1'b0, 64'd0}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   req_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [WORD_W-1:0]      rsp_tdata;

   logic [WORD_W-1:0] running_hash;
   logic [WORD_W-1:0] pending_hashes [$];
   int unsigned       fail_count;
   int unsigned       sent_count;

   murmur64a_hash_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(3, 1);
      end
      return $urandom_range(40, 4);
   endfunction

   task automatic fold_word(input logic [WORD_W-1:0] word, input logic [COUNT_W-1:0] count,
         input logic is_first, input logic [KLEN_W-1:0] klen, output logic [WORD_W-1:0] hash);
      logic [WORD_W-1:0]  h;
      logic [WORD_W-1:0]  k;
      logic [WORD_W-1:0]  mask;
      logic [COUNT_W-1:0] bytes;
      bytes = (count > FULL_COUNT) ? FULL_COUNT : count;
      h = is_first ? (SEED ^ ({{(WORD_W-KLEN_W){1'b0}}, klen} * MIX_MUL)) : running_hash;
      if (bytes == FULL_COUNT) begin
         k = word * MIX_MUL;
         k = k ^ (k >> MIX_SHIFT);
         k = k * MIX_MUL;
         h = (h ^ k) * MIX_MUL;
      end else if (bytes != 0) begin
         mask = (64'd1 << (bytes * 8)) - 64'd1;
         h = (h ^ (word & mask)) * MIX_MUL;
      end
      running_hash = h;
      h = h ^ (h >> MIX_SHIFT);
      h = h * MIX_MUL;
      hash = h ^ (h >> MIX_SHIFT);
   endtask

   task automatic send_request(input logic [WORD_W-1:0] word, input logic [COUNT_W-1:0] count,
         input logic is_first, input logic is_last, input logic [KLEN_W-1:0] klen,
         input bit eager, input logic typed, input logic [WORD_W-1:0] typed_hash);
      int unsigned       gap;
      logic [WORD_W-1:0] hash;
      gap = eager ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {klen, count, word};
      req_tuser  <= is_first;
      req_tlast  <= is_last;
      do @(posedge clock); while (!req_tready);
      fold_word(word, count, is_first, klen, hash);
      if (is_last) begin
         pending_hashes = {pending_hashes, (typed ? typed_hash : hash)};
      end
      sent_count++;
   endtask

   task automatic drain_requests();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_hashes.size() != 0);
   endtask

   task automatic note_failure(input string what, input logic [WORD_W-1:0] want,
         input logic [WORD_W-1:0] got);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
      end
   endtask

   initial begin : rsp_pacing
      int unsigned stall;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(15) == 0) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(120, 40)) @(posedge clock);
         end else begin
            stall = pick_gap();
            if (stall != 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            repeat ($urandom_range(6, 1)) @(posedge clock);
         end
      end
   end

   initial begin : rsp_check
      int unsigned       quiet;
      logic [WORD_W-1:0] want;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_hashes.size() == 0) begin
               note_failure("hash with no request pending", '0, rsp_tdata);
            end else begin
               want = pending_hashes.pop_front();
               if (rsp_tdata !== want) begin
                  note_failure("hash_value mismatch", want, rsp_tdata);
               end
            end
         end
         if ((!reset && rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            quiet = 0;
         end else begin
            quiet++;
            if (quiet >= IDLE_LIMIT) begin
               $display("murmur64a_hash_top_tb: FAIL");
               $finish;
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned        len;
      int unsigned        words;
      int unsigned        idx;
      int unsigned        sel;
      logic [COUNT_W-1:0] count;
      logic [KLEN_W-1:0]  klen;
      bit                 eager;
      bit                 cut_short;
      bit                 wrong_len;
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tuser    <= 1'b0;
      req_tlast    <= 1'b0;
      running_hash = '0;
      fail_count   = 0;
      sent_count   = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < ROW_COUNT; i++) begin
         send_request(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].count, DIRECTED_ROWS[i].is_first,
            DIRECTED_ROWS[i].is_last, DIRECTED_ROWS[i].klen, 1'b0, DIRECTED_ROWS[i].typed,
            DIRECTED_ROWS[i].hash);
      end
      drain_requests();

      sent_count = 0;
      while (sent_count < RANDOM_ITEMS) begin
         sel = $urandom_range(99);
         eager = ($urandom_range(7) == 0);
         if (sel < 12) begin
            send_request({$urandom, $urandom}, 4'($urandom_range(15)), 1'($urandom),
               1'($urandom), 31'($urandom), eager, 1'b0, '0);
         end else begin
            len = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(40);
            words = (len == 0) ? 1 : (len + 7) / 8;
            cut_short = (sel >= 95);
            wrong_len = ($urandom_range(9) == 0);
            klen = wrong_len ? 31'($urandom) : 31'(len);
            for (idx = 0; idx < words; idx++) begin
               if (len == 0) begin
                  count = '0;
               end else if (idx == words - 1 && len % 8 != 0) begin
                  count = 4'(len % 8);
               end else begin
                  count = FULL_COUNT;
                  if ($urandom_range(15) == 0) begin
                     count = 4'($urandom_range(15, 9));
                  end
               end
               send_request({$urandom, $urandom}, count, idx == 0,
                  (idx == words - 1) && !cut_short, klen, eager, 1'b0, '0);
            end
         end
         if ($urandom_range(149) == 0) begin
            drain_requests();
         end
      end
      req_tvalid <= 1'b0;

      while (pending_hashes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_hashes.size() == 0) begin
         $display("murmur64a_hash_top_tb: PASS");
      end else begin
         $display("murmur64a_hash_top_tb: FAIL");
      end
      $finish;
   end

endmodule
